// File: rtl/tsrbl_pkg.sv
// Shared type, constants and serial-number helper for the SACK receive block list.
// No dependencies; every other file refers to it by scoped names.
`default_nettype none
package tsrbl_pkg;

  localparam int SEQ_W   = 32;
  localparam int LEN_W   = 16;
  localparam int CNT_W   = 3;
  localparam int IDX_W   = 2;
  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = 1;
  localparam int QCNT_W  = 2;

  // Candidate block handed from the front to the back
  typedef struct packed {
    logic [SEQ_W-1:0] cs;
    logic [SEQ_W-1:0] ce;
    logic [SEQ_W-1:0] nxt;
  } cand_t;

  // a strictly after b in serial-number order
  function automatic logic ser_after(input logic [SEQ_W-1:0] a, input logic [SEQ_W-1:0] b);
    logic [SEQ_W-1:0] d;
    d = a - b;
    return (d != '0) && !d[SEQ_W-1];
  endfunction

endpackage
`default_nettype wire

// File: rtl/tsrbl_if.sv
// Request channel interfaces: segment input and block-list result output.
// Depends on tsrbl_pkg for field widths.
`default_nettype none
interface tsrbl_in_if;
  logic                          valid;
  logic                          ready;
  logic [tsrbl_pkg::SEQ_W-1:0]   seg_seq;
  logic [tsrbl_pkg::LEN_W-1:0]   seg_len;
  logic [tsrbl_pkg::SEQ_W-1:0]   rcv_next;
  modport source (output valid, seg_seq, seg_len, rcv_next, input ready);
  modport sink   (input valid, seg_seq, seg_len, rcv_next, output ready);
endinterface

interface tsrbl_out_if;
  logic                          valid;
  logic                          ready;
  logic [tsrbl_pkg::CNT_W-1:0]   block_count;
  logic [tsrbl_pkg::IDX_W-1:0]   block_index;
  logic [tsrbl_pkg::SEQ_W-1:0]   block_start;
  logic [tsrbl_pkg::SEQ_W-1:0]   block_end;
  logic                          last_block;
  modport source (output valid, block_count, block_index, block_start, block_end, last_block,
                  input ready);
  modport sink   (input valid, block_count, block_index, block_start, block_end, last_block,
                  output ready);
endinterface
`default_nettype wire

// File: rtl/tsrbl_front.sv
// Front stage: accepts segment requests and forms the candidate block [seq, seq+len).
// Depends on tsrbl_pkg and tsrbl_in_if.
`default_nettype none
module tsrbl_front (
  input  wire logic           clk,
  input  wire logic           rst_n,
  tsrbl_in_if.sink            in_chan,
  output tsrbl_pkg::cand_t    q_data,
  output logic                q_valid,
  input  wire logic           q_ready
);

  logic             v_r;
  tsrbl_pkg::cand_t cand_r;
  logic             acc;

  assign in_chan.ready = !v_r || q_ready;
  assign acc           = in_chan.valid && in_chan.ready;
  assign q_valid       = v_r;
  assign q_data        = cand_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (acc) begin
      v_r <= 1'b1;
    end else if (q_ready) begin
      v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      cand_r.cs  <= in_chan.seg_seq;
      cand_r.ce  <= in_chan.seg_seq + tsrbl_pkg::SEQ_W'(in_chan.seg_len);
      cand_r.nxt <= in_chan.rcv_next;
    end
  end

endmodule
`default_nettype wire

// File: rtl/tsrbl_queue.sv
// Short request queue between the front and back stages.
// Depends on tsrbl_pkg for the candidate type and depth.
`default_nettype none
module tsrbl_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire tsrbl_pkg::cand_t  push_data,
  input  wire logic              push_valid,
  output logic                   push_ready,
  output tsrbl_pkg::cand_t       pop_data,
  output logic                   pop_valid,
  input  wire logic              pop_ready
);

  tsrbl_pkg::cand_t                     mem_r [tsrbl_pkg::QDEPTH];
  logic [tsrbl_pkg::QPTR_W-1:0]         wp_r;
  logic [tsrbl_pkg::QPTR_W-1:0]         rp_r;
  logic [tsrbl_pkg::QCNT_W-1:0]         cnt_r;
  logic                                 push;
  logic                                 pop;

  assign push_ready = (cnt_r != tsrbl_pkg::QCNT_W'(tsrbl_pkg::QDEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_data   = mem_r[rp_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_data;
  end

endmodule
`default_nettype wire

// File: rtl/tsrbl_back.sv
// Back stage: scans the stored list one entry a cycle, merges, commits and reports the list.
// Depends on tsrbl_pkg and tsrbl_out_if.
`default_nettype none
module tsrbl_back #(
  parameter int MAX_BLOCKS = 4
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire tsrbl_pkg::cand_t  q_data,
  input  wire logic              q_valid,
  output logic                   q_ready,
  tsrbl_out_if.source            out_chan
);

  localparam int CW = $clog2(MAX_BLOCKS + 1);
  localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int SW = tsrbl_pkg::SEQ_W;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_COMMIT = 2'd2;
  localparam logic [1:0] S_EMIT   = 2'd3;

  logic [1:0]    st_r, st_nxt;
  logic [SW-1:0] cs_r, cs_nxt;
  logic [SW-1:0] ce_r, ce_nxt;
  logic [SW-1:0] nxt_r;
  logic [CW-1:0] idx_r;
  logic [CW-1:0] kept_r;
  logic [CW-1:0] cnt_r;
  logic [CW-1:0] emit_r;
  logic [SW-1:0] keep_s_r [MAX_BLOCKS];
  logic [SW-1:0] keep_e_r [MAX_BLOCKS];
  logic [SW-1:0] lst_s_r  [MAX_BLOCKS];
  logic [SW-1:0] lst_e_r  [MAX_BLOCKS];

  logic          ov_r;
  logic [tsrbl_pkg::CNT_W-1:0] oc_r;
  logic [tsrbl_pkg::IDX_W-1:0] oi_r;
  logic [SW-1:0] os_r, oe_r;
  logic          ol_r;

  logic [SW-1:0] s, e;
  logic          scan_go, drop, ovl, keep;
  logic          head;
  logic [CW-1:0] kept_eff;
  logic          slot_free, emit_go, emit_last, pop;

  assign s         = lst_s_r[idx_r[IW-1:0]];
  assign e         = lst_e_r[idx_r[IW-1:0]];
  assign scan_go   = (st_r == S_SCAN) && (idx_r < cnt_r) && (kept_r < CW'(MAX_BLOCKS));
  assign drop      = !tsrbl_pkg::ser_after(s, nxt_r);
  assign ovl       = !tsrbl_pkg::ser_after(cs_r, e) && !tsrbl_pkg::ser_after(s, ce_r);
  assign keep      = scan_go && !drop && !ovl;

  assign head      = tsrbl_pkg::ser_after(cs_r, nxt_r);
  assign kept_eff  = (head && (kept_r > CW'(MAX_BLOCKS - 1))) ? CW'(MAX_BLOCKS - 1) : kept_r;

  assign slot_free = !ov_r || out_chan.ready;
  assign emit_go   = (st_r == S_EMIT) && slot_free;
  assign emit_last = (cnt_r == '0) || (emit_r + 1'b1 == cnt_r);
  assign pop       = q_valid && ((st_r == S_IDLE) || (emit_go && emit_last));
  assign q_ready   = pop;

  always_comb begin
    cs_nxt = cs_r;
    ce_nxt = ce_r;
    if (scan_go && !drop && ovl) begin
      if (tsrbl_pkg::ser_after(cs_r, s)) cs_nxt = s;
      if (tsrbl_pkg::ser_after(e, ce_r)) ce_nxt = e;
    end
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      S_IDLE:   if (q_valid) st_nxt = S_SCAN;
      S_SCAN:   if (!scan_go) st_nxt = S_COMMIT;
      S_COMMIT: st_nxt = S_EMIT;
      S_EMIT:   if (emit_go && emit_last) st_nxt = q_valid ? S_SCAN : S_IDLE;
      default:  st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_IDLE;
      cnt_r  <= '0;
      idx_r  <= '0;
      kept_r <= '0;
      emit_r <= '0;
      ov_r   <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (pop) begin
        idx_r  <= '0;
        kept_r <= '0;
      end else if (scan_go) begin
        idx_r <= idx_r + 1'b1;
        if (keep) kept_r <= kept_r + 1'b1;
      end
      if (st_r == S_COMMIT) begin
        cnt_r  <= CW'(head) + kept_eff;
        emit_r <= '0;
      end else if (emit_go) begin
        emit_r <= emit_r + 1'b1;
      end
      if (emit_go) begin
        ov_r <= 1'b1;
      end else if (out_chan.ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cs_r  <= q_data.cs;
      ce_r  <= q_data.ce;
      nxt_r <= q_data.nxt;
    end else begin
      cs_r <= cs_nxt;
      ce_r <= ce_nxt;
    end
    if (keep) begin
      keep_s_r[kept_r[IW-1:0]] <= s;
      keep_e_r[kept_r[IW-1:0]] <= e;
    end
    if (st_r == S_COMMIT) begin
      for (int j = 0; j < MAX_BLOCKS; j++) begin
        if (head) begin
          if (j == 0) begin
            lst_s_r[j] <= cs_r;
            lst_e_r[j] <= ce_r;
          end else begin
            lst_s_r[j] <= keep_s_r[IW'(j - 1)];
            lst_e_r[j] <= keep_e_r[IW'(j - 1)];
          end
        end else begin
          lst_s_r[j] <= keep_s_r[j];
          lst_e_r[j] <= keep_e_r[j];
        end
      end
    end
    if (emit_go) begin
      oc_r <= tsrbl_pkg::CNT_W'(cnt_r);
      oi_r <= tsrbl_pkg::IDX_W'(emit_r);
      os_r <= (cnt_r == '0) ? '0 : lst_s_r[emit_r[IW-1:0]];
      oe_r <= (cnt_r == '0) ? '0 : lst_e_r[emit_r[IW-1:0]];
      ol_r <= emit_last;
    end
  end

  assign out_chan.valid       = ov_r;
  assign out_chan.block_count = oc_r;
  assign out_chan.block_index = oi_r;
  assign out_chan.block_start = os_r;
  assign out_chan.block_end   = oe_r;
  assign out_chan.last_block  = ol_r;

endmodule
`default_nettype wire

// File: rtl/tcp_sack_receive_block_list_top.sv
// Receiver SACK block list: each segment request updates the stored list (most recent first),
// then the whole list is reported, one result request per block, or a single zero result when
// the list is empty. The back stage scans the stored blocks one per cycle through one serial
// compare unit. The front stage and a two-entry queue take further segments while the back
// stage works, and the registered output lets a finished result wait without stopping the
// scan of the next segment.
// Depends on tsrbl_pkg, tsrbl_if, tsrbl_front, tsrbl_queue and tsrbl_back.
`default_nettype none
module tcp_sack_receive_block_list_top #(
  parameter int MAX_BLOCKS = 4
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  tsrbl_in_if.sink      in_chan,
  tsrbl_out_if.source   out_chan
);

  tsrbl_pkg::cand_t f_data, q_data;
  logic             f_valid, f_ready;
  logic             q_valid, q_ready;

  tsrbl_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .q_data  (f_data),
    .q_valid (f_valid),
    .q_ready (f_ready)
  );

  tsrbl_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_data  (f_data),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .pop_data   (q_data),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready)
  );

  tsrbl_back #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_data   (q_data),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .out_chan (out_chan)
  );

endmodule
`default_nettype wire

// File: dv/tcp_sack_receive_block_list_top_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for tcp_sack_receive_block_list_top: sends segment requests, keeps its
// own copy of the SACK block list and checks every reported block against it.
// Depends on tsrbl_pkg, the tsrbl_if channel interfaces and the block RTL.
module tcp_sack_receive_block_list_top_tb;

  localparam int SEQ_W = tsrbl_pkg::SEQ_W;
  localparam int LEN_W = tsrbl_pkg::LEN_W;
  localparam int CNT_W = tsrbl_pkg::CNT_W;
  localparam int IDX_W = tsrbl_pkg::IDX_W;
  localparam int LIST_DEPTH = 4;
  localparam int CLK_PERIOD = 12;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic [IDX_W-1:0] index;
    logic [SEQ_W-1:0] left_edge;
    logic [SEQ_W-1:0] right_edge;
    logic             last;
  } sack_entry_t;

  logic clk;
  logic rst_n;

  tsrbl_in_if  seg_if ();
  tsrbl_out_if blk_if ();

  tcp_sack_receive_block_list_top #(
    .MAX_BLOCKS (LIST_DEPTH)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (seg_if),
    .out_chan (blk_if)
  );

  logic [SEQ_W-1:0] sack_lo [LIST_DEPTH];
  logic [SEQ_W-1:0] sack_hi [LIST_DEPTH];
  int               sack_cnt = 0;
  sack_entry_t      sack_expect [$];
  int               mismatches = 0;
  int               src_idle_pct = 0;
  int               snk_stall_pct = 0;
  int               hold_left = 0;
  logic [SEQ_W-1:0] win_nxt;

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  function automatic bit seq_after(input logic [SEQ_W-1:0] a, input logic [SEQ_W-1:0] b);
    logic [SEQ_W-1:0] d;
    d = a - b;
    return (d != '0) && (d < 32'h8000_0000);
  endfunction

  function automatic void predict_sack_list(input logic [SEQ_W-1:0] seq,
                                            input logic [LEN_W-1:0] len,
                                            input logic [SEQ_W-1:0] nxt);
    logic [SEQ_W-1:0] cs;
    logic [SEQ_W-1:0] ce;
    logic [SEQ_W-1:0] keep_lo [LIST_DEPTH];
    logic [SEQ_W-1:0] keep_hi [LIST_DEPTH];
    int               kept;
    int               head;
    sack_entry_t      ent;
    cs   = seq;
    ce   = seq + {{(SEQ_W-LEN_W){1'b0}}, len};
    kept = 0;
    head = 0;
    for (int i = 0; i < sack_cnt && kept < LIST_DEPTH; i++) begin
      if (!seq_after(sack_lo[i], nxt)) continue;
      if (!seq_after(cs, sack_hi[i]) && !seq_after(sack_lo[i], ce)) begin
        if (seq_after(cs, sack_lo[i])) cs = sack_lo[i];
        if (seq_after(sack_hi[i], ce)) ce = sack_hi[i];
      end else begin
        keep_lo[kept] = sack_lo[i];
        keep_hi[kept] = sack_hi[i];
        kept++;
      end
    end
    if (seq_after(cs, nxt)) begin
      sack_lo[0] = cs;
      sack_hi[0] = ce;
      head = 1;
      if (kept > LIST_DEPTH - 1) kept = LIST_DEPTH - 1;
    end
    for (int i = 0; i < kept; i++) begin
      sack_lo[head + i] = keep_lo[i];
      sack_hi[head + i] = keep_hi[i];
    end
    sack_cnt = head + kept;
    if (sack_cnt == 0) begin
      ent.count      = '0;
      ent.index      = '0;
      ent.left_edge  = '0;
      ent.right_edge = '0;
      ent.last       = 1'b1;
      sack_expect.push_back(ent);
    end else begin
      for (int k = 0; k < sack_cnt; k++) begin
        ent.count      = CNT_W'(sack_cnt);
        ent.index      = IDX_W'(k);
        ent.left_edge  = sack_lo[k];
        ent.right_edge = sack_hi[k];
        ent.last       = (k + 1 == sack_cnt);
        sack_expect.push_back(ent);
      end
    end
  endfunction

  task automatic send_segment(input logic [SEQ_W-1:0] seq, input logic [LEN_W-1:0] len,
                              input logic [SEQ_W-1:0] nxt);
    while ($urandom_range(99) < src_idle_pct) begin
      seg_if.valid <= 1'b0;
      @(posedge clk);
    end
    seg_if.valid    <= 1'b1;
    seg_if.seg_seq  <= seq;
    seg_if.seg_len  <= len;
    seg_if.rcv_next <= nxt;
    @(posedge clk);
    while (!seg_if.ready) @(posedge clk);
    predict_sack_list(seq, len, nxt);
  endtask

  always @(posedge clk) begin
    if (hold_left > 0) begin
      blk_if.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else begin
      blk_if.ready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  always @(posedge clk) begin : check_blocks
    sack_entry_t got;
    sack_entry_t want;
    if (rst_n && blk_if.valid && blk_if.ready) begin
      got.count      = blk_if.block_count;
      got.index      = blk_if.block_index;
      got.left_edge  = blk_if.block_start;
      got.right_edge = blk_if.block_end;
      got.last       = blk_if.last_block;
      if (sack_expect.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected block: cnt=%0d idx=%0d [%h,%h) last=%0b",
                   got.count, got.index, got.left_edge, got.right_edge, got.last);
      end else begin
        want = sack_expect.pop_front();
        if (got.count !== want.count || got.index !== want.index ||
            got.left_edge !== want.left_edge || got.right_edge !== want.right_edge ||
            got.last !== want.last) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("mismatch: exp %0d/%0d [%h,%h) %0b, got %0d/%0d [%h,%h) %0b",
                     want.count, want.index, want.left_edge, want.right_edge, want.last,
                     got.count, got.index, got.left_edge, got.right_edge, got.last);
        end
      end
    end
  end

  task automatic test_directed();
    src_idle_pct = 0;
    snk_stall_pct <= 0;
    // in-order data on an empty list
    send_segment(32'd100, 16'd50, 32'd150);
    send_segment(32'd1000, 16'd100, 32'd150);
    send_segment(32'd2000, 16'd0, 32'd150);
    // touch and merge with a stored block
    send_segment(32'd1100, 16'd100, 32'd150);
    // fill the list, then push past capacity
    send_segment(32'd3000, 16'd10, 32'd150);
    send_segment(32'd4000, 16'd10, 32'd150);
    send_segment(32'd5000, 16'd10, 32'd150);
    send_segment(32'd1500, 16'd2000, 32'd150);
    // advance receive-next over stored blocks
    send_segment(32'd6000, 16'd0, 32'd3600);
    send_segment(32'd3600, 16'd100, 32'd3700);
    send_segment(32'd10000, 16'd10, 32'd10010);
    // half-range distance is not after
    send_segment(32'h8000_0000, 16'd5, 32'h0000_0000);
    send_segment(32'h7FFF_FFFF, 16'hFFFF, 32'h0000_0000);
    // wrap around zero
    send_segment(32'hFFFF_FFF0, 16'h0040, 32'hFFFF_FF00);
    send_segment(32'h0000_0020, 16'h0100, 32'hFFFF_FF00);
    send_segment(32'hFFFF_FFFF, 16'd0, 32'hFFFF_FF00);
    send_segment(32'h0000_0000, 16'hFFFF, 32'hFFFF_FFFE);
    send_segment(32'h0001_0000, 16'd1, 32'hFFFF_FFFE);
  endtask

  task automatic test_random(input int src_pct, input int snk_pct, input int n_items);
    logic [SEQ_W-1:0] seq;
    logic [SEQ_W-1:0] nxt;
    logic [LEN_W-1:0] len;
    int               pick;
    src_idle_pct = src_pct;
    snk_stall_pct <= snk_pct;
    for (int n = 0; n < n_items; n++) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        seq = $urandom;
        len = LEN_W'($urandom_range(0, 65535));
        nxt = $urandom;
      end else begin
        if (pick < 12)
          win_nxt = $urandom_range(1) ? $urandom : 32'hFFFF_F000 + $urandom_range(0, 4095);
        else if (pick < 35)
          win_nxt = win_nxt + $urandom_range(0, 900);
        nxt = win_nxt;
        if (pick >= 95) seq = win_nxt - $urandom_range(0, 500);
        else seq = win_nxt + $urandom_range(1, 3000);
        len = (pick < 16) ? LEN_W'($urandom_range(0, 65535)) : LEN_W'($urandom_range(0, 400));
      end
      send_segment(seq, len, nxt);
    end
  endtask

  task automatic test_backpressure();
    src_idle_pct = 0;
    snk_stall_pct <= 0;
    hold_left <= 300;
    for (int n = 0; n < 16; n++) begin
      if ($urandom_range(3) == 0) win_nxt = win_nxt + $urandom_range(0, 600);
      send_segment(win_nxt + $urandom_range(1, 3000), LEN_W'($urandom_range(0, 400)), win_nxt);
    end
  endtask

  initial begin
    #(5_000_000);
    $display("[tcp_sack_receive_block_list_top] ERROR");
    $finish;
  end

  initial begin
    rst_n           = 1'b0;
    seg_if.valid    = 1'b0;
    seg_if.seg_seq  = '0;
    seg_if.seg_len  = '0;
    seg_if.rcv_next = '0;
    blk_if.ready    = 1'b0;
    win_nxt         = $urandom;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(0, 0, 60);
    test_random(78, 0, 60);
    test_random(0, 78, 60);
    test_random(26, 26, 60);
    test_backpressure();
    seg_if.valid <= 1'b0;
    while (sack_expect.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (mismatches == 0 && sack_expect.size() == 0) begin
      $display("[tcp_sack_receive_block_list_top] OK");
    end else begin
      $display("[tcp_sack_receive_block_list_top] ERROR");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/tsrbl_pkg.sv
rtl/tsrbl_if.sv
rtl/tsrbl_front.sv
rtl/tsrbl_queue.sv
rtl/tsrbl_back.sv
rtl/tcp_sack_receive_block_list_top.sv
dv/tcp_sack_receive_block_list_top_tb.sv
